[hdl/bom_sniffing_text_decoder_assert.svh]
// Assertion macros used by the text decoder RTL.
`ifndef BOM_SNIFFING_TEXT_DECODER_ASSERT_SVH
`define BOM_SNIFFING_TEXT_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BOMDEC_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bomdec: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BOMDEC_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bomdec: next-cycle check failed");

`endif

[hdl/bomdec_pkg.sv]
// Types, codes and byte-order mark constants for the text decoder.
package bomdec_pkg;

    typedef enum logic [2:0] {
        MODE_AUTO = 3'd0,
        MODE_ANSI = 3'd1,
        MODE_UTF8 = 3'd2,
        MODE_LE   = 3'd3,
        MODE_BE   = 3'd4,
        MODE_RAW  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_UTF8 = 2'd0,
        KIND_LE   = 2'd1,
        KIND_BE   = 2'd2,
        KIND_ANSI = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_MARK = 2'd1,
        ST_BAD_LEAD = 2'd2
    } status_t;

    localparam int CP_W = 31;

    localparam logic [7:0] BOM_UTF8_0 = 8'hEF;
    localparam logic [7:0] BOM_UTF8_1 = 8'hBB;
    localparam logic [7:0] BOM_UTF8_2 = 8'hBF;
    localparam logic [7:0] BOM_FE     = 8'hFE;
    localparam logic [7:0] BOM_FF     = 8'hFF;
    localparam logic [7:0] BOM_ANSI_0 = 8'h5C;
    localparam logic [7:0] BOM_ANSI_1 = 8'h75;

    typedef struct packed {
        mode_t             mode;
        logic [1:0]        mark_stage;
        kind_t             mark_kind;
        logic [2:0]        pending;
        logic [CP_W-1:0]   acc;
        logic [7:0]        held;
    } dec_state_t;

    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic              raw_pair;
        status_t           status;
    } dec_result_t;

    // Second byte expected after the first byte of each mark.
    function automatic logic [7:0] mark_second(input kind_t kind);
        logic [7:0] val;
        unique case (kind)
            KIND_UTF8: val = BOM_UTF8_1;
            KIND_LE:   val = BOM_FE;
            KIND_BE:   val = BOM_FF;
            KIND_ANSI: val = BOM_ANSI_1;
            default:   val = BOM_ANSI_1;
        endcase
        return val;
    endfunction

    function automatic mode_t mark_mode(input kind_t kind);
        mode_t val;
        unique case (kind)
            KIND_UTF8: val = MODE_UTF8;
            KIND_LE:   val = MODE_LE;
            KIND_BE:   val = MODE_BE;
            KIND_ANSI: val = MODE_ANSI;
            default:   val = MODE_ANSI;
        endcase
        return val;
    endfunction

    function automatic dec_state_t cleared_state(input mode_t mode);
        dec_state_t s;
        s            = '0;
        s.mode       = mode;
        s.mark_kind  = KIND_UTF8;
        return s;
    endfunction

endpackage

[hdl/bomdec_step.sv]
// Combinational decode of one byte: next decoder state and optional result.
module bomdec_step (
    input  bomdec_pkg::mode_t       sel,
    input  bomdec_pkg::dec_state_t  cur,
    input  logic [7:0]              data,
    output bomdec_pkg::dec_state_t  nxt,
    output bomdec_pkg::dec_result_t res
);

    logic [bomdec_pkg::CP_W-1:0] acc_shift;

    assign acc_shift = {cur.acc[bomdec_pkg::CP_W-7:0], data[5:0]};

    always_comb
    begin
        nxt = cur;
        res = '0;
        unique case (cur.mode)
            bomdec_pkg::MODE_AUTO:
            begin
                if (cur.mark_stage == 2'd0)
                begin
                    nxt.mark_stage = 2'd1;
                    priority if (data == bomdec_pkg::BOM_UTF8_0)
                        nxt.mark_kind = bomdec_pkg::KIND_UTF8;
                    else if (data == bomdec_pkg::BOM_FF)
                        nxt.mark_kind = bomdec_pkg::KIND_LE;
                    else if (data == bomdec_pkg::BOM_FE)
                        nxt.mark_kind = bomdec_pkg::KIND_BE;
                    else if (data == bomdec_pkg::BOM_ANSI_0)
                        nxt.mark_kind = bomdec_pkg::KIND_ANSI;
                    else
                    begin
                        // No mark: this byte is the first ANSI byte.
                        nxt = bomdec_pkg::cleared_state(bomdec_pkg::MODE_ANSI);
                        if (data[7])
                        begin
                            nxt.held    = data;
                            nxt.pending = 3'd1;
                        end
                        else
                        begin
                            res.emit       = 1'b1;
                            res.code_point = {{(bomdec_pkg::CP_W-8){1'b0}}, data};
                        end
                    end
                end
                else if (cur.mark_stage == 2'd1)
                begin
                    if (data != bomdec_pkg::mark_second(cur.mark_kind))
                    begin
                        nxt        = bomdec_pkg::cleared_state(bomdec_pkg::MODE_AUTO);
                        res.emit   = 1'b1;
                        res.status = bomdec_pkg::ST_BAD_MARK;
                    end
                    else if (cur.mark_kind == bomdec_pkg::KIND_UTF8)
                        nxt.mark_stage = 2'd2;
                    else
                        nxt = bomdec_pkg::cleared_state(
                            bomdec_pkg::mark_mode(cur.mark_kind));
                end
                else
                begin
                    if (data != bomdec_pkg::BOM_UTF8_2)
                    begin
                        nxt        = bomdec_pkg::cleared_state(bomdec_pkg::MODE_AUTO);
                        res.emit   = 1'b1;
                        res.status = bomdec_pkg::ST_BAD_MARK;
                    end
                    else
                        nxt = bomdec_pkg::cleared_state(bomdec_pkg::MODE_UTF8);
                end
            end
            bomdec_pkg::MODE_ANSI:
            begin
                if (cur.pending != 3'd0)
                begin
                    nxt.pending    = 3'd0;
                    res.emit       = 1'b1;
                    res.raw_pair   = 1'b1;
                    res.code_point = {{(bomdec_pkg::CP_W-16){1'b0}}, cur.held, data};
                end
                else if (data[7])
                begin
                    nxt.held    = data;
                    nxt.pending = 3'd1;
                end
                else
                begin
                    res.emit       = 1'b1;
                    res.code_point = {{(bomdec_pkg::CP_W-8){1'b0}}, data};
                end
            end
            bomdec_pkg::MODE_UTF8:
            begin
                if (cur.pending != 3'd0)
                begin
                    nxt.acc     = acc_shift;
                    nxt.pending = cur.pending - 3'd1;
                    if (cur.pending == 3'd1)
                    begin
                        res.emit       = 1'b1;
                        res.code_point = acc_shift;
                    end
                end
                else if (!data[7])
                begin
                    res.emit       = 1'b1;
                    res.code_point = {{(bomdec_pkg::CP_W-8){1'b0}}, data};
                end
                else
                begin
                    priority if (data[7:1] == 7'b1111110)
                    begin
                        nxt.acc     = {{(bomdec_pkg::CP_W-1){1'b0}}, data[0]};
                        nxt.pending = 3'd5;
                    end
                    else if (data[7:2] == 6'b111110)
                    begin
                        nxt.acc     = {{(bomdec_pkg::CP_W-2){1'b0}}, data[1:0]};
                        nxt.pending = 3'd4;
                    end
                    else if (data[7:3] == 5'b11110)
                    begin
                        nxt.acc     = {{(bomdec_pkg::CP_W-3){1'b0}}, data[2:0]};
                        nxt.pending = 3'd3;
                    end
                    else if (data[7:4] == 4'b1110)
                    begin
                        nxt.acc     = {{(bomdec_pkg::CP_W-4){1'b0}}, data[3:0]};
                        nxt.pending = 3'd2;
                    end
                    else if (data[7:5] == 3'b110)
                    begin
                        nxt.acc     = {{(bomdec_pkg::CP_W-5){1'b0}}, data[4:0]};
                        nxt.pending = 3'd1;
                    end
                    else
                    begin
                        // Continuation byte, FE or FF in lead position.
                        if (sel == bomdec_pkg::MODE_AUTO)
                            nxt = bomdec_pkg::cleared_state(bomdec_pkg::MODE_AUTO);
                        res.emit   = 1'b1;
                        res.status = bomdec_pkg::ST_BAD_LEAD;
                    end
                end
            end
            bomdec_pkg::MODE_LE, bomdec_pkg::MODE_BE:
            begin
                if (cur.pending == 3'd0)
                begin
                    nxt.held    = data;
                    nxt.pending = 3'd1;
                end
                else
                begin
                    nxt.pending = 3'd0;
                    res.emit    = 1'b1;
                    if (cur.mode == bomdec_pkg::MODE_LE)
                        res.code_point = {{(bomdec_pkg::CP_W-16){1'b0}}, data, cur.held};
                    else
                        res.code_point = {{(bomdec_pkg::CP_W-16){1'b0}}, cur.held, data};
                end
            end
            default:
            begin
                res.emit       = 1'b1;
                res.code_point = {{(bomdec_pkg::CP_W-8){1'b0}}, data};
            end
        endcase
    end

endmodule

[hdl/bom_sniffing_text_decoder.sv]
// An accepted byte is held in the input byte register, and its character is then
// registered in the result register. Throughput: one byte per cycle while the output
// is not held off; the decode state steps combinationally between the two registers.
// A byte that completes no character produces no output transfer.
// Reset (rst_n low, asynchronous) selects auto detect and clears all partial
// sequences; the block accepts bytes in the first cycle after reset.
`include "bom_sniffing_text_decoder_assert.svh"

module bom_sniffing_text_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  encoding_select,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] code_point,
    output logic        raw_pair,
    output logic [1:0]  status,
    output logic [2:0]  active_encoding
);

    bomdec_pkg::mode_t       sel_reg;
    bomdec_pkg::dec_state_t  state_reg;
    bomdec_pkg::dec_state_t  state_next;
    bomdec_pkg::dec_result_t step_res;
    bomdec_pkg::mode_t       cfg_mode;

    logic                              in_full_reg;
    logic [7:0]                        in_byte_reg;
    logic                              out_valid_reg;
    logic [bomdec_pkg::CP_W-1:0]       cp_reg;
    logic                              raw_reg;
    bomdec_pkg::status_t               status_reg;
    bomdec_pkg::mode_t                 enc_reg;
    logic                              advance;
    logic                              cfg_xfer;

    assign advance   = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;
    assign cfg_ready = !in_full_reg;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_mode  = (encoding_select > 3'(bomdec_pkg::MODE_RAW)) ?
                       bomdec_pkg::MODE_RAW : bomdec_pkg::mode_t'(encoding_select);

    bomdec_step u_step (
        .sel  (sel_reg),
        .cur  (state_reg),
        .data (in_byte_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= bomdec_pkg::MODE_AUTO;
            state_reg     <= bomdec_pkg::cleared_state(bomdec_pkg::MODE_AUTO);
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                sel_reg   <= cfg_mode;
                state_reg <= bomdec_pkg::cleared_state(cfg_mode);
            end
            else if (advance)
                state_reg <= state_next;

            if (in_valid && in_ready)
                in_full_reg <= 1'b1;
            else if (advance)
                in_full_reg <= 1'b0;

            if (advance)
                out_valid_reg <= step_res.emit;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= data_byte;
        if (advance && step_res.emit)
        begin
            cp_reg     <= step_res.code_point;
            raw_reg    <= step_res.raw_pair;
            status_reg <= step_res.status;
            enc_reg    <= state_next.mode;
        end
    end

    assign out_valid       = out_valid_reg;
    assign code_point      = cp_reg;
    assign raw_pair        = raw_reg;
    assign status          = status_reg;
    assign active_encoding = enc_reg;

    // Error transfers carry no character.
    `BOMDEC_IMPLIES(a_err_no_char, out_valid && (status != 2'(bomdec_pkg::ST_OK)), code_point == '0 && !raw_pair)
    // Only ANSI decoding produces raw pairs.
    `BOMDEC_IMPLIES(a_raw_is_ansi, out_valid && raw_pair, active_encoding == 3'(bomdec_pkg::MODE_ANSI))
    // A bad lead byte leaves the decoder in UTF-8 or back in auto detect.
    `BOMDEC_IMPLIES(a_bad_lead_mode, out_valid && (status == 2'(bomdec_pkg::ST_BAD_LEAD)), active_encoding == 3'(bomdec_pkg::MODE_UTF8) || active_encoding == 3'(bomdec_pkg::MODE_AUTO))
    // A configuration write reloads the active mode from the new select value.
    `BOMDEC_NEXT(a_cfg_loads_mode, cfg_xfer, state_reg.mode == sel_reg && state_reg.pending == 3'd0)

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the byte-order-mark sniffing text decoder.
module tb_top;
    import bomdec_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_PHASE = 5;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            raw;
        status_t         st;
        mode_t           mode;
    } char_t;

    typedef struct packed {
        logic        wr_sel;
        logic [2:0]  sel;
        logic [7:0]  b;
        logic        typed;
        char_t       want;
    } script_row_t;

    localparam char_t NO_CHAR = '{31'd0, 1'b0, ST_OK, MODE_AUTO};

    // Each row may first rewrite the mode register, then sends one byte. Rows with
    // typed set carry the character they must produce.
    localparam int SCRIPT_LEN = 28;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b1, MODE_AUTO, 8'hEF, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'hBB, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'hBF, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h80, 1'b1, '{31'd0, 1'b0, ST_BAD_LEAD, MODE_AUTO}},
        '{1'b0, MODE_AUTO, 8'h00, 1'b1, '{31'd0, 1'b0, ST_OK, MODE_ANSI}},
        '{1'b1, MODE_AUTO, 8'hFF, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'hFE, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h41, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h00, 1'b0, NO_CHAR},
        '{1'b1, MODE_AUTO, 8'hFE, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'hFF, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h12, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h34, 1'b0, NO_CHAR},
        '{1'b1, MODE_AUTO, 8'h5C, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h75, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h81, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h40, 1'b1, '{31'h8140, 1'b1, ST_OK, MODE_ANSI}},
        '{1'b1, MODE_AUTO, 8'hEF, 1'b0, NO_CHAR},
        '{1'b0, MODE_AUTO, 8'h00, 1'b1, '{31'd0, 1'b0, ST_BAD_MARK, MODE_AUTO}},
        // An out-of-range register value falls back to raw byte mode.
        '{1'b1, 3'd7,      8'hFF, 1'b1, '{31'hFF, 1'b0, ST_OK, MODE_RAW}},
        '{1'b1, MODE_UTF8, 8'hFD, 1'b0, NO_CHAR},
        '{1'b0, MODE_UTF8, 8'hBF, 1'b0, NO_CHAR},
        '{1'b0, MODE_UTF8, 8'hBF, 1'b0, NO_CHAR},
        '{1'b0, MODE_UTF8, 8'hBF, 1'b0, NO_CHAR},
        '{1'b0, MODE_UTF8, 8'hBF, 1'b0, NO_CHAR},
        '{1'b0, MODE_UTF8, 8'hBF, 1'b1, '{31'h7FFFFFFF, 1'b0, ST_OK, MODE_UTF8}},
        '{1'b0, MODE_UTF8, 8'hFF, 1'b1, '{31'd0, 1'b0, ST_BAD_LEAD, MODE_UTF8}},
        '{1'b1, MODE_ANSI, 8'h7F, 1'b1, '{31'h7F, 1'b0, ST_OK, MODE_ANSI}}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  encoding_select;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [30:0] code_point;
    logic        raw_pair;
    logic [1:0]  status;
    logic [2:0]  active_encoding;

    bom_sniffing_text_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .encoding_select (encoding_select),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .code_point      (code_point),
        .raw_pair        (raw_pair),
        .status          (status),
        .active_encoding (active_encoding)
    );

    // Decoder state as predicted from the bytes accepted so far.
    mode_t           sel_mode;
    mode_t           cur_mode;
    logic [1:0]      mark_stage;
    kind_t           mark_kind;
    logic [2:0]      owed;
    logic [CP_W-1:0] acc;
    logic [7:0]      held;

    char_t      expected_chars[$];
    logic [7:0] phase_bytes[$];
    int         err_count = 0;
    bit         no_idle = 1'b0;
    bit         hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("bom_sniffing_text_decoder: mismatch");
        $finish;
    end

    function automatic void clear_seq();
        mark_stage = 2'd0;
        mark_kind  = KIND_UTF8;
        owed       = 3'd0;
        acc        = '0;
        held       = 8'd0;
    endfunction

    function automatic void predict_select(input logic [2:0] v);
        sel_mode = (v > MODE_RAW) ? MODE_RAW : mode_t'(v);
        cur_mode = sel_mode;
        clear_seq();
    endfunction

    function automatic char_t make_char(input logic [CP_W-1:0] cp, input logic raw,
                                        input status_t st);
        char_t c;
        c.cp   = cp;
        c.raw  = raw;
        c.st   = st;
        c.mode = cur_mode;
        return c;
    endfunction

    function automatic bit ansi_step(input logic [7:0] b, output char_t c);
        c = NO_CHAR;
        if (owed != 3'd0)
        begin
            owed = 3'd0;
            c = make_char({15'd0, held, b}, 1'b1, ST_OK);
            return 1'b1;
        end
        if (!b[7])
        begin
            c = make_char({23'd0, b}, 1'b0, ST_OK);
            return 1'b1;
        end
        held = b;
        owed = 3'd1;
        return 1'b0;
    endfunction

    function automatic bit utf8_step(input logic [7:0] b, output char_t c);
        c = NO_CHAR;
        if (owed != 3'd0)
        begin
            acc  = {acc[CP_W-7:0], b[5:0]};
            owed = owed - 3'd1;
            if (owed == 3'd0)
            begin
                c = make_char(acc, 1'b0, ST_OK);
                return 1'b1;
            end
            return 1'b0;
        end
        if (!b[7])
        begin
            c = make_char({23'd0, b}, 1'b0, ST_OK);
            return 1'b1;
        end
        casez (b)
            8'b1111_110?: begin acc = {30'd0, b[0]};   owed = 3'd5; end
            8'b1111_10??: begin acc = {29'd0, b[1:0]}; owed = 3'd4; end
            8'b1111_0???: begin acc = {28'd0, b[2:0]}; owed = 3'd3; end
            8'b1110_????: begin acc = {27'd0, b[3:0]}; owed = 3'd2; end
            8'b110?_????: begin acc = {26'd0, b[4:0]}; owed = 3'd1; end
            default:
            begin
                // A bad lead drops auto-detected UTF-8 back to sniffing.
                if (sel_mode == MODE_AUTO)
                begin
                    cur_mode = MODE_AUTO;
                    clear_seq();
                end
                c = make_char('0, 1'b0, ST_BAD_LEAD);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic bit sniff_step(input logic [7:0] b, output char_t c);
        logic [7:0] second;
        c = NO_CHAR;
        if (mark_stage == 2'd0)
        begin
            if (b == BOM_UTF8_0)
                mark_kind = KIND_UTF8;
            else if (b == BOM_FF)
                mark_kind = KIND_LE;
            else if (b == BOM_FE)
                mark_kind = KIND_BE;
            else if (b == BOM_ANSI_0)
                mark_kind = KIND_ANSI;
            else
            begin
                cur_mode = MODE_ANSI;
                clear_seq();
                return ansi_step(b, c);
            end
            mark_stage = 2'd1;
            return 1'b0;
        end
        if (mark_stage == 2'd1)
        begin
            case (mark_kind)
                KIND_UTF8: second = BOM_UTF8_1;
                KIND_LE:   second = BOM_FE;
                KIND_BE:   second = BOM_FF;
                default:   second = BOM_ANSI_1;
            endcase
            if (b != second)
            begin
                clear_seq();
                c = make_char('0, 1'b0, ST_BAD_MARK);
                return 1'b1;
            end
            case (mark_kind)
                KIND_UTF8:
                begin
                    mark_stage = 2'd2;
                    return 1'b0;
                end
                KIND_LE: cur_mode = MODE_LE;
                KIND_BE: cur_mode = MODE_BE;
                default: cur_mode = MODE_ANSI;
            endcase
            clear_seq();
            return 1'b0;
        end
        clear_seq();
        if (b != BOM_UTF8_2)
        begin
            c = make_char('0, 1'b0, ST_BAD_MARK);
            return 1'b1;
        end
        cur_mode = MODE_UTF8;
        return 1'b0;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output char_t c);
        c = NO_CHAR;
        case (cur_mode)
            MODE_AUTO: return sniff_step(b, c);
            MODE_ANSI: return ansi_step(b, c);
            MODE_UTF8: return utf8_step(b, c);
            MODE_LE, MODE_BE:
            begin
                if (owed == 3'd0)
                begin
                    held = b;
                    owed = 3'd1;
                    return 1'b0;
                end
                owed = 3'd0;
                if (cur_mode == MODE_LE)
                    c = make_char({15'd0, b, held}, 1'b0, ST_OK);
                else
                    c = make_char({15'd0, held, b}, 1'b0, ST_OK);
                return 1'b1;
            end
            default:
            begin
                c = make_char({23'd0, b}, 1'b0, ST_OK);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Pushes a byte-order mark, a broken one, or a plain first byte, and returns
    // the mode that the content after it should be written for.
    function automatic mode_t push_mark();
        logic [7:0] mk[$];
        logic [7:0] b;
        mode_t      target;
        int         r;
        int         idx;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            do
                b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            while (b == BOM_UTF8_0 || b == BOM_FF || b == BOM_FE || b == BOM_ANSI_0);
            phase_bytes.push_back(b);
            return MODE_ANSI;
        end
        case ($urandom_range(0, 3))
            0:       begin mk = '{BOM_UTF8_0, BOM_UTF8_1, BOM_UTF8_2}; target = MODE_UTF8; end
            1:       begin mk = '{BOM_FF, BOM_FE};         target = MODE_LE;   end
            2:       begin mk = '{BOM_FE, BOM_FF};         target = MODE_BE;   end
            default: begin mk = '{BOM_ANSI_0, BOM_ANSI_1}; target = MODE_ANSI; end
        endcase
        if (r >= 85)
        begin
            idx = $urandom_range(1, mk.size() - 1);
            mk[idx] = 8'($urandom_range(0, 255));
            target = MODE_AUTO;
        end
        foreach (mk[i])
            phase_bytes.push_back(mk[i]);
        return target;
    endfunction

    // Returns 1 when the character pushed starts with an invalid lead byte.
    function automatic bit push_utf8_char();
        int         r;
        int         len;
        logic [7:0] lead;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            phase_bytes.push_back(8'($urandom_range(0, 127)));
            return 1'b0;
        end
        if (r < 90)
        begin
            len  = $urandom_range(2, 6);
            lead = 8'($urandom_range(0, 255));
            case (len)
                2:       lead[7:5] = 3'b110;
                3:       lead[7:4] = 4'b1110;
                4:       lead[7:3] = 5'b11110;
                5:       lead[7:2] = 6'b111110;
                default: lead[7:1] = 7'b1111110;
            endcase
            phase_bytes.push_back(lead);
            // Continuation bytes are not checked, so some of them are arbitrary.
            repeat (len - 1)
                phase_bytes.push_back(($urandom_range(0, 7) == 0) ?
                                      8'($urandom_range(0, 255)) :
                                      {2'b10, 6'($urandom_range(0, 63))});
            return 1'b0;
        end
        case ($urandom_range(0, 2))
            0:       phase_bytes.push_back(BOM_FE);
            1:       phase_bytes.push_back(BOM_FF);
            default: phase_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
        endcase
        return 1'b1;
    endfunction

    function automatic void build_phase(input logic [2:0] sel, input int n);
        mode_t m;
        phase_bytes.delete();
        m = (sel > MODE_RAW) ? MODE_RAW : mode_t'(sel);
        while (phase_bytes.size() < n)
        begin
            case (m)
                MODE_AUTO: m = push_mark();
                MODE_UTF8:
                begin
                    if (push_utf8_char() && sel == MODE_AUTO)
                        m = MODE_AUTO;
                end
                MODE_ANSI:
                begin
                    if ($urandom_range(0, 1) == 0)
                        phase_bytes.push_back(8'($urandom_range(0, 127)));
                    else
                    begin
                        phase_bytes.push_back(8'($urandom_range(128, 255)));
                        phase_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
                default: phase_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic typed, input char_t want);
        int    gap;
        bit    got;
        char_t c;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        got = decode_byte(b, c);
        if (typed)
            expected_chars.push_back(want);
        else if (got)
            expected_chars.push_back(c);
    endtask

    // The mode register is only rewritten once the decoder has drained.
    task automatic write_select(input logic [2:0] v);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid       <= 1'b1;
        encoding_select <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        predict_select(v);
    endtask

    task automatic check_char();
        char_t want;
        if (expected_chars.size() == 0)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("unexpected character: cp=%h raw=%0d status=%0d mode=%0d",
                         code_point, raw_pair, status, active_encoding);
            return;
        end
        want = expected_chars.pop_front();
        if (code_point !== want.cp || raw_pair !== want.raw || status !== want.st ||
            active_encoding !== want.mode)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("character differs: exp cp=%h raw=%0d status=%0d mode=%0d, %s",
                         want.cp, want.raw, want.st, want.mode,
                         $sformatf("got cp=%h raw=%0d status=%0d mode=%0d",
                                   code_point, raw_pair, status, active_encoding));
        end
    endtask

    initial
    begin : sink
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            check_char();
        end
    end

    initial
    begin : source
        int         phase_idx;
        int         total;
        int         n;
        logic [2:0] sel;
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        encoding_select <= MODE_AUTO;
        in_valid        <= 1'b0;
        data_byte       <= 8'd0;
        predict_select(MODE_AUTO);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (SCRIPT[i].wr_sel)
                write_select(SCRIPT[i].sel);
            feed_byte(SCRIPT[i].b, SCRIPT[i].typed, SCRIPT[i].want);
        end

        // Every register value comes up once in the first phases, then mostly auto.
        phase_idx = 0;
        total     = 0;
        while (total < RANDOM_ITEMS)
        begin
            if (phase_idx < 8)
                sel = phase_idx[2:0];
            else if ($urandom_range(0, 1) == 0)
                sel = MODE_AUTO;
            else
                sel = 3'($urandom_range(0, 7));
            write_select(sel);
            no_idle = ($urandom_range(0, 4) == 0);
            n = $urandom_range(20, 80);
            // The receiver holds off while bytes keep coming, so the input backs up.
            if (phase_idx == HOLD_PHASE)
            begin
                no_idle      = 1'b1;
                hold_off_req = 1'b1;
                n            = 100;
            end
            build_phase(sel, n);
            foreach (phase_bytes[i])
                feed_byte(phase_bytes[i], 1'b0, NO_CHAR);
            total += phase_bytes.size();
            phase_idx++;
        end

        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("bom_sniffing_text_decoder: match");
        else
            $display("bom_sniffing_text_decoder: mismatch");
        $finish;
    end

endmodule
